// ===== rtl/sias_pkg.sv =====
// Shared types and constants for the safety interlock and alarm sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sias_pkg;

    // Field widths
    localparam int ANGLE_W  = 14;   // unsigned angle, 1/64 degree
    localparam int TILT_W   = 15;   // signed tilt, 1/64 degree
    localparam int TIME_W   = 32;   // millisecond timestamp
    localparam int PERIOD_W = 16;   // period / duration in ms
    localparam int TONE_W   = 12;   // tone in Hz
    localparam int PHASES_W = 8;    // multi-beep phase counter
    localparam int COUNT_W  = 7;    // beep count field
    localparam int CMD_W    = 8;    // ASCII command byte
    localparam int ADDR_W   = 4;    // APB byte address
    localparam int DATA_W   = 32;   // APB data

    // Operation codes
    typedef enum logic [1:0] {
        OP_UPDATE     = 2'd0,
        OP_COMMAND    = 2'd1,
        OP_BEEP_ONCE  = 2'd2,
        OP_BEEP_MULTI = 2'd3
    } t_op;

    // Register indexes (word address)
    localparam logic [1:0] REG_DEFL_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TILT_LIMIT   = 2'd1;
    localparam logic [1:0] REG_SIREN_PERIOD = 2'd2;
    localparam logic [1:0] REG_BEEP_PERIOD  = 2'd3;

    // Register reset values
    localparam logic [ANGLE_W-1:0]  RST_DEFL_LIMIT   = 14'd960;   // 15 degrees
    localparam logic [ANGLE_W-1:0]  RST_TILT_LIMIT   = 14'd2880;  // 45 degrees
    localparam logic [PERIOD_W-1:0] RST_SIREN_PERIOD = 16'd140;
    localparam logic [PERIOD_W-1:0] RST_BEEP_PERIOD  = 16'd100;

    // Tones
    localparam logic [TONE_W-1:0] TONE_SIREN_DEFAULT   = 12'd2600;
    localparam logic [TONE_W-1:0] TONE_SIREN_RESONANCE = 12'd2900;
    localparam logic [TONE_W-1:0] TONE_SIREN_WIND      = 12'd2300;
    localparam logic [TONE_W-1:0] TONE_BEEP            = 12'd2500;

    // Command bytes
    localparam logic [CMD_W-1:0] CMD_RELAY_ON_LO  = 8'h72;  // 'r'
    localparam logic [CMD_W-1:0] CMD_RELAY_ON_UP  = 8'h52;  // 'R'
    localparam logic [CMD_W-1:0] CMD_RELAY_OFF_LO = 8'h63;  // 'c'
    localparam logic [CMD_W-1:0] CMD_RELAY_OFF_UP = 8'h43;  // 'C'
    localparam logic [CMD_W-1:0] CMD_BEEPS_LO     = 8'h62;  // 'b'
    localparam logic [CMD_W-1:0] CMD_BEEPS_UP     = 8'h42;  // 'B'

    localparam logic [PHASES_W-1:0] CMD_BEEP_PHASES = 8'd6;  // three beeps

    typedef struct packed {
        logic [ANGLE_W-1:0]  deflection_limit;
        logic [ANGLE_W-1:0]  tilt_limit;
        logic [PERIOD_W-1:0] siren_period_ms;
        logic [PERIOD_W-1:0] beep_period_ms;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/sias_cfg.sv =====
// APB register file for the interlock limits and timer periods.
// Depends on sias_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sias_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sias_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sias_pkg::DATA_W-1:0] pwdata,
    output logic      [sias_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output sias_pkg::t_cfg                   o_cfg
);
    import sias_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deflection_limit <= RST_DEFL_LIMIT;
            r_cfg.tilt_limit       <= RST_TILT_LIMIT;
            r_cfg.siren_period_ms  <= RST_SIREN_PERIOD;
            r_cfg.beep_period_ms   <= RST_BEEP_PERIOD;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEFL_LIMIT:   r_cfg.deflection_limit <= pwdata[ANGLE_W-1:0];
                REG_TILT_LIMIT:   r_cfg.tilt_limit       <= pwdata[ANGLE_W-1:0];
                REG_SIREN_PERIOD: r_cfg.siren_period_ms  <= pwdata[PERIOD_W-1:0];
                REG_BEEP_PERIOD:  r_cfg.beep_period_ms   <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DEFL_LIMIT:   prdata = {{(DATA_W-ANGLE_W){1'b0}}, r_cfg.deflection_limit};
            REG_TILT_LIMIT:   prdata = {{(DATA_W-ANGLE_W){1'b0}}, r_cfg.tilt_limit};
            REG_SIREN_PERIOD: prdata = {{(DATA_W-PERIOD_W){1'b0}}, r_cfg.siren_period_ms};
            REG_BEEP_PERIOD:  prdata = {{(DATA_W-PERIOD_W){1'b0}}, r_cfg.beep_period_ms};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/safety_interlock_alarm_sequencer.sv =====
// Top level: safety interlock and alarm sequencer (input stage, step logic, result).
// Depends on sias_pkg and sias_cfg.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    i_operation .. i_beep_count
//  result    out        o_out_valid / i_out_stall  o_interlock_engaged .. o_tone_hz
//  config    in         APB psel/penable/pready    paddr[3:2] word index, pwdata
//
//  One request per cycle sustained while the result is not stalled; the input register
//  feeds the step logic, which loads the state registers, which are also the result register.
//  Synchronous active-low reset; no clearing pass, the block is ready right after.
//  A stalled result holds; the input register keeps taking requests while the
//  result waits, and o_in_stall rises only once both stages are full.

module safety_interlock_alarm_sequencer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [sias_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic                          i_imu_ok,
    input  wire logic [sias_pkg::ANGLE_W-1:0]  i_total_deflection,
    input  wire logic signed [sias_pkg::TILT_W-1:0] i_tilt_x,
    input  wire logic signed [sias_pkg::TILT_W-1:0] i_tilt_y,
    input  wire logic                          i_resonance_hazard,
    input  wire logic                          i_wind_hazard,
    input  wire logic [sias_pkg::CMD_W-1:0]    i_command_byte,
    input  wire logic [sias_pkg::PERIOD_W-1:0] i_beep_duration_ms,
    input  wire logic [sias_pkg::COUNT_W-1:0]  i_beep_count,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_interlock_engaged,
    output logic                               o_high_tilt,
    output logic                               o_hazard_active,
    output logic                               o_relay_drive,
    output logic                               o_buzzer_on,
    output logic      [sias_pkg::TONE_W-1:0]   o_tone_hz,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sias_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sias_pkg::DATA_W-1:0]   pwdata,
    output logic      [sias_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import sias_pkg::*;

    t_cfg w_cfg;

    sias_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------- handshake ----------------
    logic r_s1_vld, n_s1_vld;
    logic r_out_vld, n_out_vld;
    logic w_out_free;   // result register can load this cycle
    logic w_step;       // input register moves into the step logic
    logic w_s1_free;    // input register can take a request

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_step     = r_s1_vld && w_out_free;
    assign w_s1_free  = !r_s1_vld || w_step;
    assign o_in_stall = !w_s1_free;
    assign n_s1_vld   = i_in_valid ? 1'b1 : (r_s1_vld && !w_step);
    assign n_out_vld  = w_step || (r_out_vld && i_out_stall);

    // ---------------- input register ----------------
    t_op                      r_s1_op;
    logic [TIME_W-1:0]        r_s1_now;
    logic                     r_s1_imu;
    logic [ANGLE_W-1:0]       r_s1_defl;
    logic [TILT_W-1:0]        r_s1_tx;
    logic [TILT_W-1:0]        r_s1_ty;
    logic                     r_s1_res;
    logic                     r_s1_wind;
    logic [CMD_W-1:0]         r_s1_cmd;
    logic [PERIOD_W-1:0]      r_s1_dur;
    logic [COUNT_W-1:0]       r_s1_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_vld <= n_s1_vld;
            end
            r_out_vld <= n_out_vld;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_s1_free) begin
            r_s1_op   <= t_op'(i_operation);
            r_s1_now  <= i_now_ms;
            r_s1_imu  <= i_imu_ok;
            r_s1_defl <= i_total_deflection;
            r_s1_tx   <= i_tilt_x;
            r_s1_ty   <= i_tilt_y;
            r_s1_res  <= i_resonance_hazard;
            r_s1_wind <= i_wind_hazard;
            r_s1_cmd  <= i_command_byte;
            r_s1_dur  <= i_beep_duration_ms;
            r_s1_cnt  <= i_beep_count;
        end
    end

    // ---------------- sequencer state (doubles as result register) ----------------
    logic                r_siren_phase,   n_siren_phase;
    logic                r_relay_enabled, n_relay_enabled;
    logic                r_relay_level,   n_relay_level;
    logic [TIME_W-1:0]   r_beep_end,      n_beep_end;    // 0 = no one-shot pending
    logic [PHASES_W-1:0] r_beep_left,     n_beep_left;
    logic [TIME_W-1:0]   r_siren_last,    n_siren_last;
    logic [TIME_W-1:0]   r_beep_last,     n_beep_last;
    logic [TONE_W-1:0]   r_tone,          n_tone;
    logic                r_tilt,          n_tilt;
    logic                r_interlock,     n_interlock;
    logic                r_hazard,        n_hazard;

    // ---------------- step logic ----------------
    logic [TILT_W-1:0]   w_ax, w_ay;         // |tilt|, 16384 fits unsigned
    logic                w_tilt, w_haz;
    logic [TIME_W-1:0]   w_siren_gap, w_beep_gap;
    logic                w_siren_ready, w_beep_ready;
    logic                w_end_hit;
    logic [TONE_W-1:0]   w_siren_tone;
    logic [PHASES_W-1:0] w_left_dec;

    assign w_ax = r_s1_tx[TILT_W-1] ? (~r_s1_tx + 1'b1) : r_s1_tx;
    assign w_ay = r_s1_ty[TILT_W-1] ? (~r_s1_ty + 1'b1) : r_s1_ty;

    // strictly-over compares; deflection limit and tilt limit share width
    assign w_tilt = r_s1_imu &&
                    ((r_s1_defl > w_cfg.deflection_limit) ||
                     (w_ax > {1'b0, w_cfg.tilt_limit}) ||
                     (w_ay > {1'b0, w_cfg.tilt_limit}));
    assign w_haz  = r_s1_res || r_s1_wind || w_tilt;

    // wrapping elapsed time against the period
    assign w_siren_gap   = r_s1_now - r_siren_last;
    assign w_beep_gap    = r_s1_now - r_beep_last;
    assign w_siren_ready = w_siren_gap >= {{(TIME_W-PERIOD_W){1'b0}}, w_cfg.siren_period_ms};
    assign w_beep_ready  = w_beep_gap  >= {{(TIME_W-PERIOD_W){1'b0}}, w_cfg.beep_period_ms};

    // one-shot end uses a plain unsigned compare, not a wrapping one
    assign w_end_hit  = (r_beep_end != '0) && (r_s1_now >= r_beep_end);
    assign w_left_dec = r_beep_left - 1'b1;

    // siren tone by hazard priority: resonance, then wind, then tilt
    assign w_siren_tone = r_s1_res  ? TONE_SIREN_RESONANCE :
                          r_s1_wind ? TONE_SIREN_WIND : TONE_SIREN_DEFAULT;

    always_comb begin
        n_siren_phase   = r_siren_phase;
        n_relay_enabled = r_relay_enabled;
        n_relay_level   = r_relay_level;
        n_beep_end      = r_beep_end;
        n_beep_left     = r_beep_left;
        n_siren_last    = r_siren_last;
        n_beep_last     = r_beep_last;
        n_tone          = r_tone;
        n_tilt          = r_tilt;
        n_interlock     = r_interlock;
        n_hazard        = r_hazard;

        unique case (r_s1_op)
            OP_UPDATE: begin
                n_tilt   = w_tilt;
                n_hazard = w_haz;
                if (w_haz) begin
                    // tripped: relay cut, siren toggles on its own timer
                    n_interlock   = 1'b0;
                    n_relay_level = 1'b0;
                    if (w_siren_ready) begin
                        n_siren_last  = r_s1_now;
                        n_siren_phase = !r_siren_phase;
                        n_tone        = !r_siren_phase ? w_siren_tone : '0;
                    end
                end else begin
                    n_interlock   = 1'b1;
                    n_relay_level = r_relay_enabled;
                    if (w_end_hit) begin
                        n_beep_end = '0;
                        if (r_beep_left == '0) begin
                            n_tone = '0;
                        end
                    end
                    // multi-beep: odd phases sound, even phases are gaps
                    if ((r_beep_left != '0) && w_beep_ready) begin
                        n_beep_last = r_s1_now;
                        n_beep_left = w_left_dec;
                        n_tone      = w_left_dec[0] ? TONE_BEEP : '0;
                    end
                    if ((n_beep_end == '0) && (n_beep_left == '0)) begin
                        n_tone = '0;
                    end
                end
            end
            OP_COMMAND: begin
                case (r_s1_cmd) inside
                    CMD_RELAY_ON_LO, CMD_RELAY_ON_UP: begin
                        n_relay_enabled = 1'b1;
                        n_relay_level   = 1'b1;
                    end
                    CMD_RELAY_OFF_LO, CMD_RELAY_OFF_UP: begin
                        n_relay_enabled = 1'b0;
                        n_relay_level   = 1'b0;
                    end
                    CMD_BEEPS_LO, CMD_BEEPS_UP: begin
                        n_beep_left = CMD_BEEP_PHASES;
                    end
                    default: ;
                endcase
            end
            OP_BEEP_ONCE: begin
                // sounds at once, even during a hazard; end time wraps mod 2^32
                n_tone     = TONE_BEEP;
                n_beep_end = r_s1_now + {{(TIME_W-PERIOD_W){1'b0}}, r_s1_dur};
            end
            OP_BEEP_MULTI: begin
                n_beep_left = {r_s1_cnt, 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_siren_phase   <= 1'b0;
            r_relay_enabled <= 1'b1;
            r_relay_level   <= 1'b1;
            r_beep_end      <= '0;
            r_beep_left     <= '0;
            r_siren_last    <= '0;
            r_beep_last     <= '0;
            r_tone          <= '0;
            r_tilt          <= 1'b0;
            r_interlock     <= 1'b1;
            r_hazard        <= 1'b0;
        end else if (w_step) begin
            r_siren_phase   <= n_siren_phase;
            r_relay_enabled <= n_relay_enabled;
            r_relay_level   <= n_relay_level;
            r_beep_end      <= n_beep_end;
            r_beep_left     <= n_beep_left;
            r_siren_last    <= n_siren_last;
            r_beep_last     <= n_beep_last;
            r_tone          <= n_tone;
            r_tilt          <= n_tilt;
            r_interlock     <= n_interlock;
            r_hazard        <= n_hazard;
        end
    end

    // ---------------- result ----------------
    // State only moves when a result loads, so a stalled result holds.
    assign o_out_valid         = r_out_vld;
    assign o_interlock_engaged = r_interlock;
    assign o_high_tilt         = r_tilt;
    assign o_hazard_active     = r_hazard;
    assign o_relay_drive       = r_relay_level;
    assign o_tone_hz           = r_tone;
    assign o_buzzer_on         = (r_tone != '0);

endmodule

`default_nettype wire

// ===== rtl/sias_checker.sv =====
// Port-level checks on the interlock sequencer result channel, bound to the top.
// Depends on sias_pkg and safety_interlock_alarm_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module sias_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic                        o_interlock_engaged,
    input wire logic                        o_high_tilt,
    input wire logic                        o_hazard_active,
    input wire logic                        o_relay_drive,
    input wire logic                        o_buzzer_on,
    input wire logic [sias_pkg::TONE_W-1:0] o_tone_hz
);
    import sias_pkg::*;

    // interlock trips exactly when a hazard is flagged
    a_interlock_vs_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_interlock_engaged != o_hazard_active))
        else $error("interlock and hazard flags disagree");

    // high tilt is itself a hazard
    a_tilt_is_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_high_tilt) |-> o_hazard_active)
        else $error("high tilt without hazard");

    // only silence or one of the defined tones, and buzzer tracks the tone
    a_tone_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_buzzer_on == (o_tone_hz != '0)) &&
                        ((o_tone_hz == '0) || (o_tone_hz == TONE_BEEP) ||
                         (o_tone_hz == TONE_SIREN_DEFAULT) ||
                         (o_tone_hz == TONE_SIREN_RESONANCE) ||
                         (o_tone_hz == TONE_SIREN_WIND)))
        else $error("illegal tone or buzzer state");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_tone_hz) &&
            $stable(o_relay_drive) && $stable(o_hazard_active))
        else $error("result changed under stall");

endmodule

bind safety_interlock_alarm_sequencer sias_checker u_sias_checker (.*);

`default_nettype wire
